// ----- rtl/core/sc3_pkg.sv -----
// ============================================================================
// sc3_pkg: separable 3x3 convolution shared definitions
// Sizes, register indexes, request codes and the types that pass between
// the front end, the command queue and the back end.
// ============================================================================
package sc3_pkg;

    // Image limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int PEND_W     = SIZE_W;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int VPROD_W    = COEF_W + PIX_W + 1;
    localparam int VSUM_W     = 18;
    localparam int HPROD_W    = COEF_W + VSUM_W;
    localparam int OUT_W      = 27;

    // Command queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_2 = 3'd7;

    // Request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Coefficient set (reset defaults give the Sobel y-gradient)
    typedef struct packed {
        logic signed [COEF_W-1:0] v0;
        logic signed [COEF_W-1:0] v1;
        logic signed [COEF_W-1:0] v2;
        logic signed [COEF_W-1:0] h0;
        logic signed [COEF_W-1:0] h1;
        logic signed [COEF_W-1:0] h2;
    } coef_t;

    // One classified work step for the back end
    typedef struct packed {
        logic [COL_W-1:0] addr;        // line store column
        logic [PIX_W-1:0] px;          // incoming pixel
        logic             from_upper;  // take the pixel from the upper line
        logic             wr_en;       // update both line stores
        logic             shift;       // push a new vertical sum into the window
        logic             above_sel;   // row above comes from the lower line
        logic             emit_end;    // emit the right edge of the previous row
        logic             emit_inner;  // emit an interior output
        logic             left_far;    // left tap is two columns back
        logic             end_dup;     // single-column row at the right edge
        logic             frame_end;   // last output of the image
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_VPROD,
        BK_VSUM,
        BK_HPROD,
        BK_HSUM
    } back_state_t;

endpackage

// ----- rtl/core/sc3_pix_if.sv -----
// ============================================================================
// sc3_pix_if: pixel request channel
// Valid/ready channel carrying a request type and one pixel.
// ============================================================================
interface sc3_pix_if
    import sc3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

// ----- rtl/core/sc3_res_if.sv -----
// ============================================================================
// sc3_res_if: filtered result channel
// Valid/ready channel carrying one convolution result and a frame mark.
// ============================================================================
interface sc3_res_if
    import sc3_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;
    logic                    frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

// ----- rtl/core/sc3_ram.sv -----
// ============================================================================
// sc3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ============================================================================
module sc3_ram #(
    parameter  int DATA_W = 8,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/sc3_front.sv -----
// ============================================================================
// sc3_front: request front end
// Accepts pixel and flush transactions, tracks the raster position and the
// drain count, and turns each transaction into a command for the back end.
// ============================================================================
module sc3_front
    import sc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sc3_pix_if.sink           pix_in,
    input  logic [SIZE_W-1:0] image_width,
    input  logic [SIZE_W-1:0] image_height,
    input  logic              full,
    output logic              push,
    output cmd_t              cmd
);

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic              accept;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [SIZE_W-1:0] col_ext;
    logic [SIZE_W-1:0] c_full;
    logic [SIZE_W-1:0] c_inc;
    logic [SIZE_W-1:0] r_inc;
    logic [COL_W-1:0]  c;
    logic [PEND_W-1:0] w_plus1;
    logic [PEND_W-1:0] p_cap;
    logic [PEND_W-1:0] f;
    logic              tall;

    assign pix_in.ready = !full;
    assign accept       = pix_in.valid && pix_in.ready;

    // Clamp sizes into range and classify the transaction
    always_comb
    begin
        if (image_width == '0)
            w_eff = SIZE_W'(1);
        else if (image_width > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = image_width;

        if (image_height == '0)
            h_eff = SIZE_W'(1);
        else if (image_height > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = image_height;

        col_ext = {1'b0, col_reg};
        c_full  = (col_ext < w_eff) ? col_ext : w_eff - SIZE_W'(1);
        c       = c_full[COL_W-1:0];
        c_inc   = c_full + SIZE_W'(1);
        r_inc   = {1'b0, row_reg} + SIZE_W'(1);
        tall    = (h_eff >= SIZE_W'(2));

        w_plus1 = w_eff + PEND_W'(1);
        p_cap   = (pend_reg > w_plus1) ? w_plus1 : pend_reg;
        f       = w_plus1 - p_cap;

        push      = 1'b0;
        cmd       = '0;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;

        if (accept)
        begin
            if (pix_in.req_type == REQ_PIXEL)
            begin
                push           = 1'b1;
                cmd.addr       = c;
                cmd.px         = pix_in.pixel;
                cmd.wr_en      = 1'b1;
                cmd.shift      = (row_reg != '0);
                cmd.above_sel  = (row_reg > ROW_W'(1));
                cmd.emit_end   = (c == '0) && (row_reg > ROW_W'(1));
                cmd.emit_inner = (row_reg != '0) && (c != '0);
                cmd.left_far   = (c >= COL_W'(2));
                cmd.end_dup    = (w_eff < SIZE_W'(2));

                // A pixel abandons any drain and advances the raster position
                pend_next = '0;
                if (c_inc >= w_eff)
                begin
                    col_next = '0;
                    if (r_inc >= h_eff)
                    begin
                        row_next  = '0;
                        pend_next = w_plus1;
                    end
                    else
                    begin
                        row_next = r_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    col_next = c_inc[COL_W-1:0];
                end
            end
            else if (pend_reg != '0)
            begin
                // Drain step: replicate the last row below the image
                push        = 1'b1;
                cmd.end_dup = (w_eff < SIZE_W'(2));
                if (f < w_eff)
                begin
                    cmd.addr       = f[COL_W-1:0];
                    cmd.from_upper = 1'b1;
                    cmd.shift      = 1'b1;
                    cmd.above_sel  = tall;
                    cmd.emit_end   = (f == '0) && tall;
                    cmd.emit_inner = (f != '0);
                    cmd.left_far   = (f >= PEND_W'(2));
                end
                else
                begin
                    cmd.emit_end  = 1'b1;
                    cmd.frame_end = 1'b1;
                end
                pend_next = p_cap - PEND_W'(1);
            end
        end
    end

    // Hold raster position and drain count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ----- rtl/core/sc3_cmd_fifo.sv -----
// ============================================================================
// sc3_cmd_fifo: command queue
// Short first-in first-out queue of commands between front and back end.
// ============================================================================
module sc3_cmd_fifo
    import sc3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/sc3_back.sv -----
// ============================================================================
// sc3_back: convolution back end
// Runs one command at a time: line store read, vertical products, vertical
// sum and window update, then, for a command that emits, horizontal
// products and horizontal sum into the output register.
// ============================================================================
module sc3_back
    import sc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  coef_t     coef,
    input  logic      empty,
    input  cmd_t      head,
    output logic      pop,
    sc3_res_if.source res_out
);

    back_state_t state_reg, state_next;

    cmd_t                      cmd_reg, cmd_next;
    logic signed [VPROD_W-1:0] vp0_reg, vp1_reg, vp2_reg;
    logic signed [VPROD_W-1:0] vp0_next, vp1_next, vp2_next;
    logic signed [VSUM_W-1:0]  win0_reg, win1_reg, win2_reg;
    logic signed [VSUM_W-1:0]  win0_next, win1_next, win2_next;
    logic signed [VSUM_W-1:0]  ha_reg, hb_reg, hc_reg;
    logic signed [VSUM_W-1:0]  ha_next, hb_next, hc_next;
    logic signed [HPROD_W-1:0] hp0_reg, hp1_reg, hp2_reg;
    logic signed [HPROD_W-1:0] hp0_next, hp1_next, hp2_next;
    logic signed [VSUM_W-1:0]  vsum;
    logic signed [OUT_W-1:0]   hsum;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   filtered_reg,  filtered_next;
    logic                      frame_end_reg, frame_end_next;
    logic                      out_free;

    logic [PIX_W-1:0] upper_q;
    logic [PIX_W-1:0] lower_q;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] px;
    logic             wr_en;

    // Line stores: the two rows above the current one
    sc3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cmd_reg.addr),
        .wr_data (px),
        .rd_en   (pop),
        .rd_addr (head.addr),
        .rd_data (upper_q)
    );

    sc3_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cmd_reg.addr),
        .wr_data (upper_q),
        .rd_en   (pop),
        .rd_addr (head.addr),
        .rd_data (lower_q)
    );

    assign centre = upper_q;
    assign above  = cmd_reg.above_sel ? lower_q : upper_q;
    assign px     = cmd_reg.from_upper ? upper_q : cmd_reg.px;
    assign wr_en  = (state_reg == BK_VPROD) && cmd_reg.wr_en;

    assign vsum   = vp0_reg + vp1_reg + vp2_reg;
    assign hsum   = hp0_reg + hp1_reg + hp2_reg;

    assign out_free          = !out_valid_reg || res_out.ready;
    assign res_out.valid     = out_valid_reg;
    assign res_out.filtered  = filtered_reg;
    assign res_out.frame_end = frame_end_reg;

    // Sequence one command through the datapath
    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        vp0_next       = vp0_reg;
        vp1_next       = vp1_reg;
        vp2_next       = vp2_reg;
        win0_next      = win0_reg;
        win1_next      = win1_reg;
        win2_next      = win2_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        hc_next        = hc_reg;
        hp0_next       = hp0_reg;
        hp1_next       = hp1_reg;
        hp2_next       = hp2_reg;
        filtered_next  = filtered_reg;
        frame_end_next = frame_end_reg;
        out_valid_next = out_valid_reg && !res_out.ready;

        case (state_reg)
            BK_IDLE:
            begin
                // Take the next command and start the line store read
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = BK_VPROD;
                end
            end

            BK_VPROD:
            begin
                vp0_next   = $signed(coef.v0) * $signed({1'b0, px});
                vp1_next   = $signed(coef.v1) * $signed({1'b0, centre});
                vp2_next   = $signed(coef.v2) * $signed({1'b0, above});
                state_next = BK_VSUM;
            end

            BK_VSUM:
            begin
                // Pick horizontal operands, then shift the window
                if (cmd_reg.emit_end)
                begin
                    ha_next = win0_reg;
                    hb_next = win0_reg;
                    hc_next = cmd_reg.end_dup ? win0_reg : win1_reg;
                end
                else
                begin
                    ha_next = vsum;
                    hb_next = win0_reg;
                    hc_next = cmd_reg.left_far ? win1_reg : win0_reg;
                end
                if (cmd_reg.shift)
                begin
                    win2_next = win1_reg;
                    win1_next = win0_reg;
                    win0_next = vsum;
                end
                if (cmd_reg.emit_end || cmd_reg.emit_inner)
                    state_next = BK_HPROD;
                else
                    state_next = BK_IDLE;
            end

            BK_HPROD:
            begin
                hp0_next   = $signed(coef.h0) * ha_reg;
                hp1_next   = $signed(coef.h1) * hb_reg;
                hp2_next   = $signed(coef.h2) * hc_reg;
                state_next = BK_HSUM;
            end

            BK_HSUM:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    filtered_next  = hsum;
                    frame_end_next = cmd_reg.frame_end;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            win0_reg      <= win0_next;
            win1_reg      <= win1_next;
            win2_reg      <= win2_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        vp0_reg       <= vp0_next;
        vp1_reg       <= vp1_next;
        vp2_reg       <= vp2_next;
        ha_reg        <= ha_next;
        hb_reg        <= hb_next;
        hc_reg        <= hc_next;
        hp0_reg       <= hp0_next;
        hp1_reg       <= hp1_next;
        hp2_reg       <= hp2_next;
        filtered_reg  <= filtered_next;
        frame_end_reg <= frame_end_next;
    end

endmodule

// ----- rtl/core/separable_conv3_replicate_edge_unit.sv -----
// ============================================================================
// separable_conv3_replicate_edge_unit: streaming separable 3x3 convolution
// Vertical then horizontal 3-tap convolution of 8-bit raster pixels with
// replicated borders, programmable coefficients and image size.
// ============================================================================
// Usage:
//   pix_in carries one transaction per pixel in raster order (req_type
//   pixel) or a flush (req_type flush). res_out carries the signed result
//   and a frame_end mark on the last output of an image. After the last
//   pixel of an image, send image_width + 1 flushes to drain the outputs.
//   Registers are written through cfg_we / cfg_index / cfg_data while the
//   block is idle; index order is width, height, three vertical and three
//   horizontal coefficients.
//   Each output appears image_width + 1 transactions after its pixel.
//   The back end runs one transaction at a time: line store read, vertical
//   products and vertical sum, then horizontal products and horizontal sum
//   only for a transaction that gives an output.
//   A four-entry command queue lets pix_in keep accepting while the back
//   end works; ready drops only when the queue is full.
//   When res_out stalls, the finished result waits in the output register,
//   the back end waits with the next one and the queue fills up.
//   Reset restores the Sobel y-gradient and a 1024 x 1024 image; no
//   clearing pass is run, so the block accepts right after reset.
// ============================================================================
module separable_conv3_replicate_edge_unit
    import sc3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sc3_pix_if.sink               pix_in,
    sc3_res_if.source             res_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] width_reg,  width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    coef_t             coef_reg,   coef_next;

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;

    // Decode register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        coef_next   = coef_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next   = cfg_data;
                REG_IMAGE_HEIGHT: height_next  = cfg_data;
                REG_VERT_COEF_0:  coef_next.v0 = cfg_data[COEF_W-1:0];
                REG_VERT_COEF_1:  coef_next.v1 = cfg_data[COEF_W-1:0];
                REG_VERT_COEF_2:  coef_next.v2 = cfg_data[COEF_W-1:0];
                REG_HORIZ_COEF_0: coef_next.h0 = cfg_data[COEF_W-1:0];
                REG_HORIZ_COEF_1: coef_next.h1 = cfg_data[COEF_W-1:0];
                REG_HORIZ_COEF_2: coef_next.h2 = cfg_data[COEF_W-1:0];
                default:          width_next   = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_W'(MAX_WIDTH);
            height_reg  <= SIZE_W'(MAX_HEIGHT);
            coef_reg.v0 <= -COEF_W'(1);
            coef_reg.v1 <= COEF_W'(0);
            coef_reg.v2 <= COEF_W'(1);
            coef_reg.h0 <= COEF_W'(1);
            coef_reg.h1 <= COEF_W'(2);
            coef_reg.h2 <= COEF_W'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            coef_reg   <= coef_next;
        end
    end

    sc3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_in),
        .image_width  (width_reg),
        .image_height (height_reg),
        .full         (full),
        .push         (push),
        .cmd          (push_cmd)
    );

    sc3_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    sc3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef    (coef_reg),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .res_out (res_out)
    );

endmodule

// ----- tb/separable_conv3_replicate_edge_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// separable_conv3_replicate_edge_unit_tb: self-checking bench for the unit
// Streams raster pixels and flushes into the unit with random gaps on both
// channels, predicts every filtered output with a behavioral copy of the
// vertical and horizontal passes, and checks each result in order. Covers
// size clamping, mid-image resizes, cut-short drains, shrinking during a
// drain, single-row images and a long output stall that backs up the input.
// ============================================================================
module separable_conv3_replicate_edge_unit_tb;
    import sc3_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 700;
    localparam int FILL_WIDTH    = 48;
    localparam int HOLD_LEN      = 600;
    localparam int PRINT_CAP     = 30;

    typedef struct {
        logic             req_type;
        logic [PIX_W-1:0] pixel;
    } pix_req_t;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic                    frame_end;
    } filt_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sc3_pix_if pix_ch ();
    sc3_res_if res_ch ();

    separable_conv3_replicate_edge_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_ch),
        .res_out   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Pending stimulus and outputs still owed by the unit
    pix_req_t  pix_requests [$];
    filt_res_t filtered_due [$];

    // Behavioral copy of the unit's registers and state
    int unsigned              cfg_width;
    int unsigned              cfg_height;
    logic signed [COEF_W-1:0] vert_k [3];
    logic signed [COEF_W-1:0] horiz_k [3];
    logic [PIX_W-1:0]         row_upper [MAX_WIDTH];
    logic [PIX_W-1:0]         row_lower [MAX_WIDTH];
    int                       vsum_win [3];
    int unsigned              col_pos;
    int unsigned              row_pos;
    int unsigned              drain_left;

    int          gap_pct = 8;
    int unsigned items_queued;
    int unsigned pixels_sent;
    int unsigned flushes_sent;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned phase_count;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          hold_done;
    bit          hold_req;
    pix_req_t    next_req;
    filt_res_t   due;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned eff_width();
        return clamp_size(cfg_width, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_height();
        return clamp_size(cfg_height, MAX_HEIGHT);
    endfunction

    function automatic int horiz_tap(int right, int centre, int left);
        return horiz_k[0] * right + horiz_k[1] * centre + horiz_k[2] * left;
    endfunction

    // One raster step at column c; prev counts rows above, capped at two
    function automatic bit raster_advance(int unsigned c, int px, int unsigned prev,
                                          bit do_vert, int unsigned w, output int res);
        int centre;
        int above;
        int v;
        bit got;
        got = 1'b0;
        res = 0;
        // right edge of the row before last, edge column replicated
        if (c == 0 && prev >= 2)
        begin
            res = horiz_tap(vsum_win[0], vsum_win[0], (w >= 2) ? vsum_win[1] : vsum_win[0]);
            got = 1'b1;
        end
        if (do_vert && prev >= 1)
        begin
            centre = row_upper[c];
            above  = (prev >= 2) ? int'(row_lower[c]) : centre;
            v = vert_k[0] * px + vert_k[1] * centre + vert_k[2] * above;
            vsum_win[2] = vsum_win[1];
            vsum_win[1] = vsum_win[0];
            vsum_win[0] = v;
            if (c >= 1)
            begin
                res = horiz_tap(vsum_win[0], vsum_win[1],
                                (c >= 2) ? vsum_win[2] : vsum_win[1]);
                got = 1'b1;
            end
        end
        return got;
    endfunction

    // Advance the copy by one accepted transaction and record what it owes
    function automatic void conv_item(logic rt, logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned f;
        int          res;
        bit          got;
        bit          last;
        filt_res_t   owed;
        w = eff_width();
        h = eff_height();
        got = 1'b0;
        last = 1'b0;
        res = 0;
        if (rt == REQ_PIXEL)
        begin
            c = (col_pos < w) ? col_pos : w - 1;
            r = row_pos;
            drain_left = 0;
            got = raster_advance(c, int'(px), (r < 2) ? r : 2, 1'b1, w, res);
            row_lower[c] = row_upper[c];
            row_upper[c] = px;
            if (c + 1 >= w)
            begin
                col_pos = 0;
                if (r + 1 >= h)
                begin
                    row_pos = 0;
                    drain_left = w + 1;
                end
                else
                    row_pos = r + 1;
            end
            else
                col_pos = c + 1;
        end
        else if (drain_left != 0)
        begin
            if (drain_left > w + 1)
                drain_left = w + 1;
            f = w + 1 - drain_left;
            // the row below the image repeats the last row
            if (f < w)
                got = raster_advance(f, int'(row_upper[f]), (h >= 2) ? 2 : 1, 1'b1, w, res);
            else
            begin
                got = raster_advance(0, 0, 2, 1'b0, w, res);
                last = 1'b1;
            end
            drain_left--;
        end
        if (got)
        begin
            owed.filtered  = res[OUT_W-1:0];
            owed.frame_end = last;
            filtered_due.insert(filtered_due.size(), owed);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Stimulus helpers
    function automatic void queue_item(logic rt, logic [PIX_W-1:0] px);
        pix_req_t q;
        q.req_type = rt;
        q.pixel = px;
        pix_requests.insert(pix_requests.size(), q);
        items_queued++;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_pixels(int unsigned n);
        repeat (n)
            queue_item(REQ_PIXEL, pick_pixel());
    endfunction

    function automatic void queue_flushes(int unsigned n);
        repeat (n)
            queue_item(REQ_FLUSH, PIX_W'($urandom_range(255)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(11))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'($urandom_range(11, 16));
            3:       return CFG_DATA_W'($urandom_range(17, 40));
            default: return CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return CFG_DATA_W'(8'h80);
            1:       return CFG_DATA_W'(8'h7f);
            default: return CFG_DATA_W'($urandom_range(255));
        endcase
    endfunction

    // Pixels still needed to reach the last pixel of the current image
    function automatic int unsigned frame_pixels_left();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        w = eff_width();
        h = eff_height();
        c = (col_pos < w) ? col_pos : w - 1;
        return (w - c) + ((row_pos + 1 >= h) ? 0 : (h - 1 - row_pos) * w);
    endfunction

    // Write one register and mirror it in the behavioral copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = val;
            REG_IMAGE_HEIGHT: cfg_height = val;
            REG_VERT_COEF_0:  vert_k[0]  = val[COEF_W-1:0];
            REG_VERT_COEF_1:  vert_k[1]  = val[COEF_W-1:0];
            REG_VERT_COEF_2:  vert_k[2]  = val[COEF_W-1:0];
            REG_HORIZ_COEF_0: horiz_k[0] = val[COEF_W-1:0];
            REG_HORIZ_COEF_1: horiz_k[1] = val[COEF_W-1:0];
            REG_HORIZ_COEF_2: horiz_k[2] = val[COEF_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every transaction is in and every result is out, then let
    // the back end finish steps that produce nothing
    task automatic wait_idle();
        @(negedge clk);
        while (pix_requests.size() != 0 || pix_ch.valid || filtered_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Driver: advance the copy on each accepted transaction, offer the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid    <= 1'b0;
            pix_ch.req_type <= REQ_PIXEL;
            pix_ch.pixel    <= '0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                conv_item(pix_ch.req_type, pix_ch.pixel);
                if (pix_ch.req_type == REQ_PIXEL)
                    pixels_sent++;
                else
                    flushes_sent++;
            end
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (pix_requests.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    next_req = pix_requests.pop_front();
                    pix_ch.valid    <= 1'b1;
                    pix_ch.req_type <= next_req.req_type;
                    pix_ch.pixel    <= next_req.pixel;
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    // Long output hold-off: count it down once the stimulus asks for it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end
    end

    // Monitor: check each result against the oldest one owed; drive ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (filtered_due.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d, nothing owed",
                                              res_ch.filtered));
                else
                begin
                    due = filtered_due.pop_front();
                    if (res_ch.filtered !== due.filtered)
                        report_mismatch($sformatf("result %0d: filtered %0d, want %0d",
                                                  results_seen, res_ch.filtered,
                                                  due.filtered));
                    if (res_ch.frame_end !== due.frame_end)
                        report_mismatch($sformatf("result %0d: frame_end %0b, want %0b",
                                                  results_seen, res_ch.frame_end,
                                                  due.frame_end));
                end
                results_seen++;
            end
            // drop ready during the hold-off so the command queue fills
            if (hold_left != 0)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("separable_conv3_replicate_edge_unit: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned w;
        int unsigned n;
        int unsigned scenario;
        int unsigned start_count;
        int unsigned random_items;
        int unsigned waited;
        bit          big;

        // Known values on every input from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_IMAGE_WIDTH;
        cfg_data        = '0;
        pix_ch.valid    = 1'b0;
        pix_ch.req_type = REQ_PIXEL;
        pix_ch.pixel    = '0;
        res_ch.ready    = 1'b0;

        // Reset state of the copy: Sobel y-gradient, 1024 x 1024
        cfg_width  = MAX_WIDTH;
        cfg_height = MAX_HEIGHT;
        vert_k     = '{-8'sd1, 8'sd0, 8'sd1};
        horiz_k    = '{8'sd1, 8'sd2, 8'sd1};
        vsum_win   = '{0, 0, 0};
        col_pos    = 0;
        row_pos    = 0;
        drain_left = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_upper[i] = '0;
            row_lower[i] = '0;
        end

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Start a row at the reset size, then narrow the image around it.
        // The two rows written here fill both line stores over every column
        // that later phases use. The output hold-off backs up the input.
        queue_pixels(FILL_WIDTH);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(FILL_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        hold_req = 1'b1;
        queue_pixels(frame_pixels_left());
        queue_flushes(FILL_WIDTH + 1);
        wait_idle();
        phase_count++;

        // Zero sizes clamp to one; extreme taps; single-row drain and a
        // flush with nothing pending
        write_reg(REG_IMAGE_WIDTH,  '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        write_reg(REG_VERT_COEF_0,  CFG_DATA_W'(8'h80));
        write_reg(REG_VERT_COEF_1,  CFG_DATA_W'(8'h7f));
        write_reg(REG_VERT_COEF_2,  CFG_DATA_W'(8'h80));
        write_reg(REG_HORIZ_COEF_0, CFG_DATA_W'(8'h7f));
        write_reg(REG_HORIZ_COEF_1, CFG_DATA_W'(8'h80));
        write_reg(REG_HORIZ_COEF_2, CFG_DATA_W'(8'h7f));
        queue_item(REQ_PIXEL, 8'hff);
        queue_flushes(3);
        wait_idle();
        phase_count++;

        // A pixel during the drain drops it and opens a new image
        write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(2));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        queue_item(REQ_PIXEL, 8'hff);
        queue_item(REQ_PIXEL, 8'h00);
        queue_item(REQ_PIXEL, 8'h00);
        queue_item(REQ_PIXEL, 8'hff);
        queue_flushes(1);
        queue_pixels(4);
        queue_flushes(3);
        wait_idle();
        phase_count++;

        // Shrink the width mid-drain so the pending count gets capped
        write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(4));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        queue_pixels(4);
        queue_flushes(1);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
        queue_flushes(3);

        // Random phases: mostly whole images, some broken up
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            phase_count++;
            gap_pct = (phase_count >= 5 && phase_count < 10) ? 0 : 8;
            start_count = items_queued;
            big = (phase_count == 6 || phase_count == 10);
            if ($urandom_range(2) == 0)
            begin
                write_reg(REG_VERT_COEF_0,  pick_coef());
                write_reg(REG_VERT_COEF_1,  pick_coef());
                write_reg(REG_VERT_COEF_2,  pick_coef());
                write_reg(REG_HORIZ_COEF_0, pick_coef());
                write_reg(REG_HORIZ_COEF_1, pick_coef());
                write_reg(REG_HORIZ_COEF_2, pick_coef());
            end
            // two oversized settings clamp to the maximum width or height
            if (phase_count == 6)
            begin
                write_reg(REG_IMAGE_WIDTH,  '1);
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
            end
            else if (phase_count == 10)
            begin
                write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(1));
                write_reg(REG_IMAGE_HEIGHT, '1);
            end
            else
            begin
                write_reg(REG_IMAGE_WIDTH,  pick_size());
                write_reg(REG_IMAGE_HEIGHT, pick_size());
            end
            w = eff_width();
            scenario = big ? 0 : $urandom_range(9);
            case (scenario)
                0:
                begin
                    // noise: loose mix of pixels and flushes
                    repeat ($urandom_range(1, 12))
                    begin
                        if ($urandom_range(1) == 0)
                            queue_pixels(1);
                        else
                            queue_flushes(1);
                    end
                end
                1:
                begin
                    // resize partway through the image, then finish it
                    queue_pixels($urandom_range(0, frame_pixels_left() - 1));
                    wait_idle();
                    write_reg(REG_IMAGE_WIDTH,  pick_size());
                    write_reg(REG_IMAGE_HEIGHT, pick_size());
                    queue_pixels(frame_pixels_left());
                    queue_flushes(eff_width() + 1);
                end
                2:
                begin
                    // cut the drain short; the next pixels start a new image
                    queue_pixels(frame_pixels_left());
                    queue_flushes($urandom_range(0, w));
                end
                3:
                begin
                    // narrow the image while it drains
                    queue_pixels(frame_pixels_left());
                    queue_flushes($urandom_range(0, w));
                    wait_idle();
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, w)));
                    queue_flushes(eff_width() + 2);
                end
                default:
                begin
                    queue_pixels(frame_pixels_left());
                    queue_flushes(w + 1 + $urandom_range(0, 1));
                end
            endcase
            random_items += items_queued - start_count;
        end

        // Wrap up: everything in, everything owed out, back end quiet
        gap_pct = 8;
        @(negedge clk);
        while (pix_requests.size() != 0 || pix_ch.valid)
            @(negedge clk);
        waited = 0;
        while (filtered_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (filtered_due.size() != 0)
            report_mismatch($sformatf("%0d owed results never came out",
                                      filtered_due.size()));

        $display("Run covered %0d pixels and %0d flushes over %0d setting phases,",
                 pixels_sent, flushes_sent, phase_count);
        $display("with %0d filtered results checked and %0d errors.",
                 results_seen, error_count);
        if (error_count == 0)
            $display("separable_conv3_replicate_edge_unit: match");
        else
            $display("separable_conv3_replicate_edge_unit: mismatch");
        $finish;
    end

endmodule
